// ===== design/csc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, constants, reciprocal multipliers, tables and word types
// for the calendar seconds converter.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int unsigned RAW_W    = 39;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;

    localparam int unsigned DAYNUM_W = 23;   // whole days in a raw count
    localparam int unsigned TOD_W    = 17;   // seconds within a day
    localparam int unsigned DAYS_W   = 22;   // day count of a valid date

    // pipeline
    localparam int unsigned LATENCY  = 8;
    localparam int unsigned CAL_STG  = 3;

    // action codes
    localparam logic ACT_TO_CAL = 1'b0;
    localparam logic ACT_TO_SEC = 1'b1;

    // calendar constants
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned MAX_YEAR      = 9999;
    localparam int unsigned JDN_OFS       = 1721060 + 32044;
    localparam int unsigned DAYS_OFS      = 32075 + 1721060;
    localparam int unsigned YEAR_OFS      = 4800;
    localparam int unsigned YEAR_OFS_C    = 4900;
    localparam int unsigned DAYS_4Y       = 1461;
    localparam int unsigned DAYS_400Y     = 146097;
    localparam int unsigned MON_DIV       = 153;
    localparam int unsigned CENTURY       = 100;

    // 86400 = 675 << 7; divide the high part by 675 with one correction step
    localparam int unsigned DAY_LO_W  = 7;
    localparam int unsigned DAY_HI    = 675;
    localparam int unsigned DIV675_K  = 41;
    localparam longint unsigned DIV675_M = (64'd1 << DIV675_K) / DAY_HI;

    // exact reciprocals: K = input bits + ceil(log2 d), M = ceil(2^K / d)
    localparam int unsigned D400Y_K = 43;
    localparam longint unsigned D400Y_M =
        ((64'd1 << D400Y_K) + DAYS_400Y - 1) / DAYS_400Y;
    localparam int unsigned D4Y_K = 36;
    localparam longint unsigned D4Y_M = ((64'd1 << D4Y_K) + DAYS_4Y - 1) / DAYS_4Y;
    localparam int unsigned DMON_K = 19;
    localparam longint unsigned DMON_M = ((64'd1 << DMON_K) + MON_DIV - 1) / MON_DIV;
    localparam int unsigned DHR_K = 29;
    localparam longint unsigned DHR_M =
        ((64'd1 << DHR_K) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
    localparam int unsigned DMIN_K = 18;
    localparam longint unsigned DMIN_M =
        ((64'd1 << DMIN_K) + SECS_PER_MIN - 1) / SECS_PER_MIN;
    localparam int unsigned DCY_K = 21;
    localparam longint unsigned DCY_M = ((64'd1 << DCY_K) + CENTURY - 1) / CENTURY;
    localparam int unsigned DCYB_K = 22;
    localparam longint unsigned DCYB_M = ((64'd1 << DCYB_K) + CENTURY - 1) / CENTURY;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  sec;
    } t_tod;

    typedef struct packed {
        logic               ok;
        logic [RAW_W-1:0]   secs;
        t_date              date;
        t_tod               tod;
    } t_cal_word;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
            4'd2:                                      d = leap ? 5'd29 : 5'd28;
            default:                                   d = 5'd0;
        endcase
        return d;
    endfunction

    // 367 * (month - 2 + 12 * jan_feb) / 12
    function automatic logic [8:0] month_ofs(input logic [MONTH_W-1:0] mo);
        logic [8:0] v;
        case (mo)
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // (153 * m + 2) / 5, days before March-based month m
    function automatic logic [8:0] mday_ofs(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/csc_day_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_day_div
// Three-stage split of a raw second count into whole days and seconds of day.
// ----------------------------------------------------------------------------
module csc_day_div (
    input  logic                           i_clk,
    input  logic [csc_pkg::RAW_W-1:0]      i_raw,
    output logic [csc_pkg::DAYNUM_W-1:0]   o_daynum,
    output logic [csc_pkg::TOD_W-1:0]      o_tod
);

    localparam int unsigned LO_W  = csc_pkg::DAY_LO_W;
    localparam int unsigned HI_W  = csc_pkg::RAW_W - LO_W;
    localparam int unsigned P1_W  = 2 * HI_W;
    localparam int unsigned P2_W  = HI_W + 1;
    localparam int unsigned REM_W = 11;
    localparam int unsigned R_W   = 10;

    logic [P1_W-1:0]                 w_p1;
    logic [csc_pkg::DAYNUM_W-1:0]    r_q0_1;
    logic [csc_pkg::RAW_W-1:0]       r_raw_1;
    logic [P2_W-1:0]                 r_prod_2;
    logic [csc_pkg::DAYNUM_W-1:0]    r_q0_2;
    logic [csc_pkg::RAW_W-1:0]       r_raw_2;
    logic [P2_W-1:0]                 w_diff;
    logic [REM_W-1:0]                w_rem;
    logic [csc_pkg::DAYNUM_W-1:0]    n_day;
    logic [R_W-1:0]                  n_r;
    logic [csc_pkg::DAYNUM_W-1:0]    r_day_3;
    logic [csc_pkg::TOD_W-1:0]       r_tod_3;

    assign w_p1 = P1_W'(i_raw[csc_pkg::RAW_W-1:LO_W]) * P1_W'(csc_pkg::DIV675_M);

    // stage 1: estimate, stage 2: back-multiply
    always_ff @(posedge i_clk) begin
        r_q0_1   <= w_p1[csc_pkg::DIV675_K +: csc_pkg::DAYNUM_W];
        r_raw_1  <= i_raw;
        r_prod_2 <= P2_W'(r_q0_1) * P2_W'(csc_pkg::DAY_HI);
        r_q0_2   <= r_q0_1;
        r_raw_2  <= r_raw_1;
    end

    // stage 3: estimate is low by at most one
    assign w_diff = P2_W'(r_raw_2[csc_pkg::RAW_W-1:LO_W]) - r_prod_2;
    assign w_rem  = w_diff[REM_W-1:0];

    always_comb begin
        if (w_rem >= REM_W'(csc_pkg::DAY_HI)) begin
            n_day = r_q0_2 + 1'b1;
            n_r   = R_W'(w_rem - REM_W'(csc_pkg::DAY_HI));
        end else begin
            n_day = r_q0_2;
            n_r   = w_rem[R_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_day_3 <= n_day;
        r_tod_3 <= {n_r, r_raw_2[LO_W-1:0]};
    end

    assign o_daynum = r_day_3;
    assign o_tod    = r_tod_3;

endmodule

// ===== design/csc_date_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_date_split
// Four-stage Julian-day inverse: day count to year, month and day.
// ----------------------------------------------------------------------------
module csc_date_split (
    input  logic                          i_clk,
    input  logic [csc_pkg::DAYNUM_W-1:0]  i_daynum,
    output csc_pkg::t_date                o_date
);

    localparam int unsigned N_W   = csc_pkg::DAYNUM_W;
    localparam int unsigned X_W   = N_W + 2;
    localparam int unsigned PB_W  = 2 * X_W + 1;
    localparam int unsigned C_W   = 8;
    localparam int unsigned CQ_W  = 10;
    localparam int unsigned Y_W   = 15;
    localparam int unsigned T_W   = 26;
    localparam int unsigned SUB_W = 24;
    localparam int unsigned N2_W  = 9;
    localparam int unsigned M_W   = 4;
    localparam int unsigned XM_W  = 11;
    localparam int unsigned PM_W  = 23;
    localparam int unsigned YR_W  = 16;

    logic [N_W-1:0]   w_n0;
    logic [PB_W-1:0]  w_pc;
    logic [N_W-1:0]   r_n0_4;
    logic [C_W-1:0]   r_c_4;
    logic [CQ_W-1:0]  w_cq;
    logic [N_W-1:0]   w_n1;
    logic [PB_W-1:0]  w_py;
    logic [N_W-1:0]   r_n1_5;
    logic [Y_W-1:0]   r_y_5;
    logic [T_W-1:0]   w_t;
    logic [SUB_W-1:0] w_n2;
    logic [N2_W-1:0]  r_n2_6;
    logic [Y_W-1:0]   r_y_6;
    logic [XM_W-1:0]  w_xm;
    logic [PM_W-1:0]  w_pm;
    logic [M_W-1:0]   r_m_7;
    logic [N2_W-1:0]  r_n2_7;
    logic [Y_W-1:0]   r_y_7;
    logic             w_jf;
    logic [N2_W-1:0]  w_day;
    logic [YR_W-1:0]  w_year;

    // stage 4: centuries
    assign w_n0 = i_daynum + N_W'(csc_pkg::JDN_OFS);
    assign w_pc = PB_W'({w_n0, 2'b11}) * PB_W'(csc_pkg::D400Y_M);

    // stage 5: four-year cycles
    assign w_cq = (CQ_W'(r_c_4) * CQ_W'(3) + CQ_W'(3)) >> 2;
    assign w_n1 = r_n0_4 + N_W'(w_cq);
    assign w_py = PB_W'({w_n1, 2'b11}) * PB_W'(csc_pkg::D4Y_M);

    // stage 6: day of March-based year
    assign w_t  = T_W'(r_y_5) * T_W'(csc_pkg::DAYS_4Y);
    assign w_n2 = SUB_W'(r_n1_5) - w_t[T_W-1:2];

    // stage 7: March-based month
    assign w_xm = XM_W'(r_n2_6) * XM_W'(5) + XM_W'(2);
    assign w_pm = PM_W'(w_xm) * PM_W'(csc_pkg::DMON_M);

    always_ff @(posedge i_clk) begin
        r_n0_4 <= w_n0;
        r_c_4  <= w_pc[csc_pkg::D400Y_K +: C_W];
        r_n1_5 <= w_n1;
        r_y_5  <= w_py[csc_pkg::D4Y_K +: Y_W];
        r_n2_6 <= w_n2[N2_W-1:0];
        r_y_6  <= r_y_5;
        r_m_7  <= w_pm[csc_pkg::DMON_K +: M_W];
        r_n2_7 <= r_n2_6;
        r_y_7  <= r_y_6;
    end

    // final fields, registered by the top level
    assign w_jf   = (r_m_7 >= M_W'(10));
    assign w_day  = r_n2_7 - csc_pkg::mday_ofs(r_m_7) + N2_W'(1);
    assign w_year = YR_W'(r_y_7) + YR_W'(w_jf) - YR_W'(csc_pkg::YEAR_OFS);

    assign o_date.year  = w_year[csc_pkg::YEAR_W-1:0];
    assign o_date.month = w_jf ? (r_m_7 - M_W'(9)) : (r_m_7 + M_W'(3));
    assign o_date.day   = w_day[csc_pkg::DAY_W-1:0];

endmodule

// ===== design/csc_tod_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_tod_split
// Four-stage split of seconds of day into hour, minute and second.
// ----------------------------------------------------------------------------
module csc_tod_split (
    input  logic                       i_clk,
    input  logic [csc_pkg::TOD_W-1:0]  i_tod,
    output csc_pkg::t_tod              o_tod
);

    localparam int unsigned T_W   = csc_pkg::TOD_W;
    localparam int unsigned PH_W  = 35;
    localparam int unsigned R_W   = 12;
    localparam int unsigned PM_W  = 25;

    logic [PH_W-1:0]              w_ph;
    logic [csc_pkg::HOUR_W-1:0]   r_hour_4;
    logic [T_W-1:0]               r_tod_4;
    logic [T_W-1:0]               w_hs;
    logic [T_W-1:0]               w_rem5;
    logic [csc_pkg::HOUR_W-1:0]   r_hour_5;
    logic [R_W-1:0]               r_rem_5;
    logic [PM_W-1:0]              w_pm;
    logic [csc_pkg::HOUR_W-1:0]   r_hour_6;
    logic [csc_pkg::MIN_W-1:0]    r_min_6;
    logic [R_W-1:0]               r_rem_6;
    logic [R_W-1:0]               w_sec;
    logic [csc_pkg::HOUR_W-1:0]   r_hour_7;
    logic [csc_pkg::MIN_W-1:0]    r_min_7;
    logic [csc_pkg::SEC_W-1:0]    r_sec_7;

    assign w_ph   = PH_W'(i_tod) * PH_W'(csc_pkg::DHR_M);
    assign w_hs   = T_W'(r_hour_4) * T_W'(csc_pkg::SECS_PER_HOUR);
    assign w_rem5 = r_tod_4 - w_hs;
    assign w_pm   = PM_W'(r_rem_5) * PM_W'(csc_pkg::DMIN_M);
    assign w_sec  = r_rem_6 - R_W'(r_min_6) * R_W'(csc_pkg::SECS_PER_MIN);

    always_ff @(posedge i_clk) begin
        r_hour_4 <= w_ph[csc_pkg::DHR_K +: csc_pkg::HOUR_W];
        r_tod_4  <= i_tod;
        r_hour_5 <= r_hour_4;
        r_rem_5  <= w_rem5[R_W-1:0];
        r_hour_6 <= r_hour_5;
        r_min_6  <= w_pm[csc_pkg::DMIN_K +: csc_pkg::MIN_W];
        r_rem_6  <= r_rem_5;
        r_hour_7 <= r_hour_6;
        r_min_7  <= r_min_6;
        r_sec_7  <= w_sec[csc_pkg::SEC_W-1:0];
    end

    assign o_tod.hour   = r_hour_7;
    assign o_tod.minute = r_min_7;
    assign o_tod.sec    = r_sec_7;

endmodule

// ===== design/csc_cal_to_secs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_cal_to_secs
// Three-stage field check and day-number formula, calendar fields to seconds.
// ----------------------------------------------------------------------------
module csc_cal_to_secs (
    input  logic                          i_clk,
    input  logic [csc_pkg::YEAR_W-1:0]    i_year,
    input  logic [csc_pkg::MONTH_W-1:0]   i_month,
    input  logic [csc_pkg::DAY_W-1:0]     i_day,
    input  logic [csc_pkg::HOUR_W-1:0]    i_hour,
    input  logic [csc_pkg::MIN_W-1:0]     i_minute,
    input  logic [csc_pkg::SEC_W-1:0]     i_sec,
    output csc_pkg::t_cal_word            o_word
);

    localparam int unsigned YA_W  = 15;
    localparam int unsigned T1P_W = 25;
    localparam int unsigned T1_W  = T1P_W - 2;
    localparam int unsigned P3_W  = 31;
    localparam int unsigned Q3_W  = 9;
    localparam int unsigned PC_W  = 29;
    localparam int unsigned QC_W  = 8;
    localparam int unsigned T3_W  = 10;
    localparam int unsigned SUM_W = 24;
    localparam int unsigned TOD_W = csc_pkg::TOD_W;
    localparam int unsigned RAW_W = csc_pkg::RAW_W;
    localparam int unsigned Y_W   = csc_pkg::YEAR_W;

    logic                          w_jf;
    logic [YA_W-1:0]               w_ya;
    logic [YA_W-1:0]               w_yb;
    logic [T1P_W-1:0]              w_t1p;
    logic [P3_W-1:0]               w_p3;
    logic [PC_W-1:0]               w_pc;
    logic                          w_ok1;

    logic                          r_ok_1;
    logic [T1_W-1:0]               r_t1_1;
    logic [8:0]                    r_t2_1;
    logic [Q3_W-1:0]               r_q3_1;
    logic [QC_W-1:0]               r_qc_1;
    csc_pkg::t_date                r_date_1;
    csc_pkg::t_tod                 r_tod_1;

    logic [Y_W-1:0]                w_ymod;
    logic                          w_leap;
    logic [csc_pkg::DAY_W-1:0]     w_lim;
    logic [T3_W-1:0]               w_t3;
    logic [SUM_W-1:0]              w_days;
    logic [TOD_W-1:0]              w_hms;

    logic                          r_ok_2;
    logic [csc_pkg::DAYS_W-1:0]    r_days_2;
    logic [TOD_W-1:0]              r_hms_2;
    csc_pkg::t_date                r_date_2;
    csc_pkg::t_tod                 r_tod_2;

    csc_pkg::t_cal_word            r_word_3;

    // stage 1: range checks and the independent products
    assign w_jf  = (i_month <= csc_pkg::MONTH_W'(2));
    assign w_ya  = YA_W'(i_year) + YA_W'(csc_pkg::YEAR_OFS) - YA_W'(w_jf);
    assign w_yb  = YA_W'(i_year) + YA_W'(csc_pkg::YEAR_OFS_C) - YA_W'(w_jf);
    assign w_t1p = T1P_W'(w_ya) * T1P_W'(csc_pkg::DAYS_4Y);
    assign w_p3  = P3_W'(w_yb) * P3_W'(csc_pkg::DCYB_M);
    assign w_pc  = PC_W'(i_year) * PC_W'(csc_pkg::DCY_M);
    assign w_ok1 = (i_month >= csc_pkg::MONTH_W'(1)) && (i_month <= csc_pkg::MONTH_W'(12))
                && (i_year <= Y_W'(csc_pkg::MAX_YEAR))
                && (i_hour <= csc_pkg::HOUR_W'(23))
                && (i_minute <= csc_pkg::MIN_W'(59))
                && (i_sec <= csc_pkg::SEC_W'(59));

    always_ff @(posedge i_clk) begin
        r_ok_1         <= w_ok1;
        r_t1_1         <= w_t1p[T1P_W-1:2];
        r_t2_1         <= csc_pkg::month_ofs(i_month);
        r_q3_1         <= w_p3[csc_pkg::DCYB_K +: Q3_W];
        r_qc_1         <= w_pc[csc_pkg::DCY_K +: QC_W];
        r_date_1.year  <= i_year;
        r_date_1.month <= i_month;
        r_date_1.day   <= i_day;
        r_tod_1.hour   <= i_hour;
        r_tod_1.minute <= i_minute;
        r_tod_1.sec    <= i_sec;
    end

    // stage 2: leap rule, day check, day count, seconds of day
    assign w_ymod = r_date_1.year - Y_W'(r_qc_1) * Y_W'(csc_pkg::CENTURY);
    assign w_leap = (r_date_1.year[1:0] == 2'b00)
                 && ((w_ymod != '0) || (r_qc_1[1:0] == 2'b00));
    assign w_lim  = csc_pkg::month_days(r_date_1.month, w_leap);
    assign w_t3   = (T3_W'(r_q3_1) * T3_W'(3)) >> 2;
    assign w_days = SUM_W'(r_t1_1) + SUM_W'(r_t2_1) + SUM_W'(r_date_1.day)
                  - SUM_W'(w_t3) - SUM_W'(csc_pkg::DAYS_OFS);
    assign w_hms  = TOD_W'(r_tod_1.hour) * TOD_W'(csc_pkg::SECS_PER_HOUR)
                  + TOD_W'(r_tod_1.minute) * TOD_W'(csc_pkg::SECS_PER_MIN)
                  + TOD_W'(r_tod_1.sec);

    always_ff @(posedge i_clk) begin
        r_ok_2   <= r_ok_1 && (r_date_1.day != '0) && (r_date_1.day <= w_lim);
        r_days_2 <= w_days[csc_pkg::DAYS_W-1:0];
        r_hms_2  <= w_hms;
        r_date_2 <= r_date_1;
        r_tod_2  <= r_tod_1;
    end

    // stage 3: seconds
    always_ff @(posedge i_clk) begin
        r_word_3.ok   <= r_ok_2;
        r_word_3.secs <= RAW_W'(r_days_2) * RAW_W'(csc_pkg::SECS_PER_DAY) + RAW_W'(r_hms_2);
        r_word_3.date <= r_date_2;
        r_word_3.tod  <= r_tod_2;
    end

    assign o_word = r_word_3;

endmodule

// ===== design/calendar_seconds_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_seconds_converter
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the chained constant divisions of the day-number inverse,
// at most one reciprocal multiply per stage.
// Reset clears the stage valid bits and the strobe; words in flight are lost.
// ----------------------------------------------------------------------------
module calendar_seconds_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [csc_pkg::RAW_W-1:0]     i_raw_seconds,
    input  logic [csc_pkg::YEAR_W-1:0]    i_in_year,
    input  logic [csc_pkg::MONTH_W-1:0]   i_in_month,
    input  logic [csc_pkg::DAY_W-1:0]     i_in_day,
    input  logic [csc_pkg::HOUR_W-1:0]    i_in_hour,
    input  logic [csc_pkg::MIN_W-1:0]     i_in_minute,
    input  logic [csc_pkg::SEC_W-1:0]     i_in_sec,
    output logic                          o_strobe,
    output logic [csc_pkg::RAW_W-1:0]     o_total_seconds,
    output logic [csc_pkg::YEAR_W-1:0]    o_out_year,
    output logic [csc_pkg::MONTH_W-1:0]   o_out_month,
    output logic [csc_pkg::DAY_W-1:0]     o_out_day,
    output logic [csc_pkg::HOUR_W-1:0]    o_out_hour,
    output logic [csc_pkg::MIN_W-1:0]     o_out_minute,
    output logic [csc_pkg::SEC_W-1:0]     o_out_sec,
    output logic                          o_valid_res
);

    localparam int unsigned LAST = csc_pkg::LATENCY - 1;

    logic                               w_take;
    logic [LAST:1]                      r_vld;
    logic [LAST:1]                      r_act;
    logic [csc_pkg::RAW_W-1:0]          r_raw [1:LAST];
    csc_pkg::t_cal_word                 r_cal [csc_pkg::CAL_STG+1:LAST];

    logic [csc_pkg::DAYNUM_W-1:0]       w_daynum;
    logic [csc_pkg::TOD_W-1:0]          w_tod_secs;
    csc_pkg::t_date                     w_date;
    csc_pkg::t_tod                      w_tod;
    csc_pkg::t_cal_word                 w_cal;

    logic                               r_strobe;
    logic                               n_valid_res;
    logic [csc_pkg::RAW_W-1:0]          n_total;
    csc_pkg::t_date                     n_date;
    csc_pkg::t_tod                      n_tod;
    logic                               r_valid_res;
    logic [csc_pkg::RAW_W-1:0]          r_total;
    csc_pkg::t_date                     r_date;
    csc_pkg::t_tod                      r_tod;

    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    csc_day_div u_day_div (
        .i_clk    (i_clk),
        .i_raw    (i_raw_seconds),
        .o_daynum (w_daynum),
        .o_tod    (w_tod_secs)
    );

    csc_date_split u_date_split (
        .i_clk    (i_clk),
        .i_daynum (w_daynum),
        .o_date   (w_date)
    );

    csc_tod_split u_tod_split (
        .i_clk (i_clk),
        .i_tod (w_tod_secs),
        .o_tod (w_tod)
    );

    csc_cal_to_secs u_cal_to_secs (
        .i_clk    (i_clk),
        .i_year   (i_in_year),
        .i_month  (i_in_month),
        .i_day    (i_in_day),
        .i_hour   (i_in_hour),
        .i_minute (i_in_minute),
        .i_sec    (i_in_sec),
        .o_word   (w_cal)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[LAST-1:1], w_take};
            r_strobe <= r_vld[LAST];
        end
    end

    // side data traveling with the word
    always_ff @(posedge i_clk) begin
        r_act    <= {r_act[LAST-1:1], i_action};
        r_raw[1] <= i_raw_seconds;
        for (int k = 2; k <= LAST; k++) begin
            r_raw[k] <= r_raw[k-1];
        end
        r_cal[csc_pkg::CAL_STG+1] <= w_cal;
        for (int k = csc_pkg::CAL_STG + 2; k <= LAST; k++) begin
            r_cal[k] <= r_cal[k-1];
        end
    end

    // result select
    always_comb begin
        if (r_act[LAST] == csc_pkg::ACT_TO_CAL) begin
            n_valid_res = 1'b1;
            n_total     = r_raw[LAST];
            n_date      = w_date;
            n_tod       = w_tod;
        end else if (r_cal[LAST].ok) begin
            n_valid_res = 1'b1;
            n_total     = r_cal[LAST].secs;
            n_date      = r_cal[LAST].date;
            n_tod       = r_cal[LAST].tod;
        end else begin
            n_valid_res = 1'b0;
            n_total     = '0;
            n_date      = '0;
            n_tod       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid_res <= n_valid_res;
        r_total     <= n_total;
        r_date      <= n_date;
        r_tod       <= n_tod;
    end

    assign o_strobe        = r_strobe;
    assign o_valid_res     = r_valid_res;
    assign o_total_seconds = r_total;
    assign o_out_year      = r_date.year;
    assign o_out_month     = r_date.month;
    assign o_out_day       = r_date.day;
    assign o_out_hour      = r_tod.hour;
    assign o_out_minute    = r_tod.minute;
    assign o_out_sec       = r_tod.sec;

endmodule

// ===== design/csc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_props
// Port-level checks of the calendar seconds converter, bound to the top level.
// ----------------------------------------------------------------------------
module csc_props (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_action,
    input logic [csc_pkg::RAW_W-1:0]     i_raw_seconds,
    input logic                          o_strobe,
    input logic [csc_pkg::RAW_W-1:0]     o_total_seconds,
    input logic [csc_pkg::YEAR_W-1:0]    o_out_year,
    input logic [csc_pkg::MONTH_W-1:0]   o_out_month,
    input logic [csc_pkg::DAY_W-1:0]     o_out_day,
    input logic [csc_pkg::HOUR_W-1:0]    o_out_hour,
    input logic [csc_pkg::MIN_W-1:0]     o_out_minute,
    input logic [csc_pkg::SEC_W-1:0]     o_out_sec,
    input logic                          o_valid_res
);

    // every accepted word comes out a fixed number of cycles later
    property p_latency;
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(csc_pkg::LATENCY) o_strobe;
    endproperty
    a_latency: assert property (p_latency)
        else $error("csc: result strobe missing");

    // no strobe without a word accepted before it
    property p_no_extra;
        @(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##(csc_pkg::LATENCY) !o_strobe;
    endproperty
    a_no_extra: assert property (p_no_extra)
        else $error("csc: unexpected result strobe");

    // seconds-to-calendar words echo the count and always succeed
    property p_echo;
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == csc_pkg::ACT_TO_CAL)) |-> ##(csc_pkg::LATENCY)
        (o_valid_res && (o_total_seconds == $past(i_raw_seconds, csc_pkg::LATENCY)));
    endproperty
    a_echo: assert property (p_echo)
        else $error("csc: seconds echo mismatch");

    // a rejected word carries zeros
    property p_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |->
        ((o_total_seconds == '0) && (o_out_year == '0) && (o_out_month == '0)
         && (o_out_day == '0) && (o_out_hour == '0) && (o_out_minute == '0)
         && (o_out_sec == '0));
    endproperty
    a_zero: assert property (p_zero)
        else $error("csc: invalid result not cleared");

    // a good word has fields in range
    property p_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |->
        ((o_out_month >= 4'd1) && (o_out_month <= 4'd12) && (o_out_day >= 5'd1)
         && (o_out_hour <= 5'd23) && (o_out_minute <= 6'd59) && (o_out_sec <= 6'd59));
    endproperty
    a_range: assert property (p_range)
        else $error("csc: result field out of range");

endmodule

bind calendar_seconds_converter csc_props u_csc_props (.*);

// ===== bench/csc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker
// Watches the command and result ports of the calendar seconds converter,
// predicts the calendar or second-count word for every accepted command,
// and compares each result strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module csc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_action,
    input  logic [csc_pkg::RAW_W-1:0]     i_raw_seconds,
    input  logic [csc_pkg::YEAR_W-1:0]    i_in_year,
    input  logic [csc_pkg::MONTH_W-1:0]   i_in_month,
    input  logic [csc_pkg::DAY_W-1:0]     i_in_day,
    input  logic [csc_pkg::HOUR_W-1:0]    i_in_hour,
    input  logic [csc_pkg::MIN_W-1:0]     i_in_minute,
    input  logic [csc_pkg::SEC_W-1:0]     i_in_sec,
    input  logic                          i_strobe,
    input  logic [csc_pkg::RAW_W-1:0]     i_total_seconds,
    input  logic [csc_pkg::YEAR_W-1:0]    i_out_year,
    input  logic [csc_pkg::MONTH_W-1:0]   i_out_month,
    input  logic [csc_pkg::DAY_W-1:0]     i_out_day,
    input  logic [csc_pkg::HOUR_W-1:0]    i_out_hour,
    input  logic [csc_pkg::MIN_W-1:0]     i_out_minute,
    input  logic [csc_pkg::SEC_W-1:0]     i_out_sec,
    input  logic                          i_valid_res,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam longint unsigned EPOCH_JDN   = 1721060;
    localparam longint unsigned JDN_BIAS    = 32044;
    localparam longint unsigned FVF_BIAS    = 32075;
    localparam longint unsigned YEAR_BIAS   = 4800;
    localparam longint unsigned CENT_BIAS   = 4900;
    localparam longint unsigned DAYS_PER_4Y = 1461;
    localparam longint unsigned DAYS_PER_400Y = 146097;
    localparam longint unsigned MONTH_SPAN  = 153;
    localparam longint unsigned YEAR_DAYS_X = 367;

    csc_pkg::t_cal_word expected_words[$];
    int                 fail_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic csc_pkg::t_cal_word predict_conversion(
        input logic                        act,
        input logic [csc_pkg::RAW_W-1:0]   raw,
        input logic [csc_pkg::YEAR_W-1:0]  yr_in,
        input logic [csc_pkg::MONTH_W-1:0] mo_in,
        input logic [csc_pkg::DAY_W-1:0]   dy_in,
        input logic [csc_pkg::HOUR_W-1:0]  hr_in,
        input logic [csc_pkg::MIN_W-1:0]   mi_in,
        input logic [csc_pkg::SEC_W-1:0]   se_in
    );
        csc_pkg::t_cal_word w;
        longint unsigned    jdn, n, c, y, m, a, tod;
        longint unsigned    yr, mo, dy, hr, mi, se, lim, t1, t2, t3, days;
        bit                 leap;
        w = '0;
        if (act == csc_pkg::ACT_TO_CAL) begin
            jdn = raw / csc_pkg::SECS_PER_DAY + EPOCH_JDN;
            tod = raw % csc_pkg::SECS_PER_DAY;
            n = jdn + JDN_BIAS;
            c = (4 * n + 3) / DAYS_PER_400Y;
            n = n + (3 * c + 3) / 4;
            y = (4 * n + 3) / DAYS_PER_4Y;
            n = n - (DAYS_PER_4Y * y) / 4;
            m = (5 * n + 2) / MONTH_SPAN;
            a = (m + 2) / 12;
            w.ok          = 1'b1;
            w.secs        = raw;
            w.date.day    = csc_pkg::DAY_W'(n - (MONTH_SPAN * m + 2) / 5 + 1);
            w.date.month  = csc_pkg::MONTH_W'(m + 3 - 12 * a);
            w.date.year   = csc_pkg::YEAR_W'(y + a - YEAR_BIAS);
            w.tod.hour    = csc_pkg::HOUR_W'(tod / csc_pkg::SECS_PER_HOUR);
            tod           = tod % csc_pkg::SECS_PER_HOUR;
            w.tod.minute  = csc_pkg::MIN_W'(tod / csc_pkg::SECS_PER_MIN);
            w.tod.sec     = csc_pkg::SEC_W'(tod % csc_pkg::SECS_PER_MIN);
        end else begin
            yr = 64'(yr_in); mo = 64'(mo_in); dy = 64'(dy_in);
            hr = 64'(hr_in); mi = 64'(mi_in); se = 64'(se_in);
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            case (mo)
                1, 3, 5, 7, 8, 10, 12: lim = 31;
                4, 6, 9, 11:           lim = 30;
                2:                     lim = leap ? 29 : 28;
                default:               lim = 0;
            endcase
            if (yr <= csc_pkg::MAX_YEAR && hr <= 23 && mi <= 59 && se <= 59 &&
                dy >= 1 && dy <= lim) begin
                // Jan and Feb count as months 13 and 14 of the previous year
                a  = (mo <= 2) ? 1 : 0;
                t1 = DAYS_PER_4Y * (yr + YEAR_BIAS - a) / 4;
                t2 = YEAR_DAYS_X * (mo - 2 + 12 * a) / 12;
                t3 = 3 * ((yr + CENT_BIAS - a) / 100) / 4;
                days = dy + t1 + t2 - t3 - FVF_BIAS - EPOCH_JDN;
                w.ok          = 1'b1;
                w.secs        = csc_pkg::RAW_W'(days * csc_pkg::SECS_PER_DAY +
                                hr * csc_pkg::SECS_PER_HOUR +
                                mi * csc_pkg::SECS_PER_MIN + se);
                w.date.year   = yr_in;
                w.date.month  = mo_in;
                w.date.day    = dy_in;
                w.tod.hour    = hr_in;
                w.tod.minute  = mi_in;
                w.tod.sec     = se_in;
            end
        end
        return w;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        csc_pkg::t_cal_word exp_w;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result word with none expected, actual seconds %0d",
                             $time, i_total_seconds);
                end else begin
                    exp_w = expected_words.pop_front();
                    check_field("total_seconds", 64'(exp_w.secs), 64'(i_total_seconds));
                    check_field("out_year", 64'(exp_w.date.year), 64'(i_out_year));
                    check_field("out_month", 64'(exp_w.date.month), 64'(i_out_month));
                    check_field("out_day", 64'(exp_w.date.day), 64'(i_out_day));
                    check_field("out_hour", 64'(exp_w.tod.hour), 64'(i_out_hour));
                    check_field("out_minute", 64'(exp_w.tod.minute), 64'(i_out_minute));
                    check_field("out_sec", 64'(exp_w.tod.sec), 64'(i_out_sec));
                    check_field("valid_res", 64'(exp_w.ok), 64'(i_valid_res));
                end
            end
            if (i_start && !i_busy) begin
                expected_words.push_back(predict_conversion(i_action, i_raw_seconds,
                    i_in_year, i_in_month, i_in_day, i_in_hour, i_in_minute, i_in_sec));
            end
        end
        pending_count = expected_words.size();
    end

endmodule

// ===== bench/calendar_seconds_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_seconds_converter_test
// Drives directed edge dates and then random conversion words in both
// directions, with sender gaps in two of three phases; a side checker
// predicts and compares every result word; a watchdog stops a stalled run.
// ----------------------------------------------------------------------------
module calendar_seconds_converter_test;

    localparam int                RANDOM_WORDS = 1400;
    localparam int                STALL_LIMIT  = 2000;
    localparam longint unsigned   RAW_MAX_OK   = 64'd315569519999;
    localparam longint unsigned   RAW_ALL_ONES = (64'd1 << csc_pkg::RAW_W) - 1;
    localparam int unsigned       LAST_DAY     = 3652424;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_action;
    logic [csc_pkg::RAW_W-1:0]     i_raw_seconds;
    logic [csc_pkg::YEAR_W-1:0]    i_in_year;
    logic [csc_pkg::MONTH_W-1:0]   i_in_month;
    logic [csc_pkg::DAY_W-1:0]     i_in_day;
    logic [csc_pkg::HOUR_W-1:0]    i_in_hour;
    logic [csc_pkg::MIN_W-1:0]     i_in_minute;
    logic [csc_pkg::SEC_W-1:0]     i_in_sec;
    logic                          o_strobe;
    logic [csc_pkg::RAW_W-1:0]     o_total_seconds;
    logic [csc_pkg::YEAR_W-1:0]    o_out_year;
    logic [csc_pkg::MONTH_W-1:0]   o_out_month;
    logic [csc_pkg::DAY_W-1:0]     o_out_day;
    logic [csc_pkg::HOUR_W-1:0]    o_out_hour;
    logic [csc_pkg::MIN_W-1:0]     o_out_minute;
    logic [csc_pkg::SEC_W-1:0]     o_out_sec;
    logic                          o_valid_res;

    int fail_count;
    int pending_words;
    int idle_pct;
    int stall_cycles = 0;

    calendar_seconds_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_raw_seconds   (i_raw_seconds),
        .i_in_year       (i_in_year),
        .i_in_month      (i_in_month),
        .i_in_day        (i_in_day),
        .i_in_hour       (i_in_hour),
        .i_in_minute     (i_in_minute),
        .i_in_sec        (i_in_sec),
        .o_strobe        (o_strobe),
        .o_total_seconds (o_total_seconds),
        .o_out_year      (o_out_year),
        .o_out_month     (o_out_month),
        .o_out_day       (o_out_day),
        .o_out_hour      (o_out_hour),
        .o_out_minute    (o_out_minute),
        .o_out_sec       (o_out_sec),
        .o_valid_res     (o_valid_res)
    );

    csc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_action        (i_action),
        .i_raw_seconds   (i_raw_seconds),
        .i_in_year       (i_in_year),
        .i_in_month      (i_in_month),
        .i_in_day        (i_in_day),
        .i_in_hour       (i_in_hour),
        .i_in_minute     (i_in_minute),
        .i_in_sec        (i_in_sec),
        .i_strobe        (o_strobe),
        .i_total_seconds (o_total_seconds),
        .i_out_year      (o_out_year),
        .i_out_month     (o_out_month),
        .i_out_day       (o_out_day),
        .i_out_hour      (o_out_hour),
        .i_out_minute    (o_out_minute),
        .i_out_sec       (o_out_sec),
        .i_valid_res     (o_valid_res),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("calendar_seconds_converter verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(input logic act, input longint unsigned raw,
                             input int unsigned yr, input int unsigned mo,
                             input int unsigned dy, input int unsigned hr,
                             input int unsigned mi, input int unsigned se);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_raw_seconds <= csc_pkg::RAW_W'(raw);
        i_in_year     <= csc_pkg::YEAR_W'(yr);
        i_in_month    <= csc_pkg::MONTH_W'(mo);
        i_in_day      <= csc_pkg::DAY_W'(dy);
        i_in_hour     <= csc_pkg::HOUR_W'(hr);
        i_in_minute   <= csc_pkg::MIN_W'(mi);
        i_in_sec      <= csc_pkg::SEC_W'(se);
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic send_random_word();
        longint unsigned raw;
        int unsigned     mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            raw = longint'($urandom_range(0, LAST_DAY)) * csc_pkg::SECS_PER_DAY +
                  $urandom_range(0, csc_pkg::SECS_PER_DAY - 1);
            if (raw > RAW_MAX_OK) raw = RAW_MAX_OK;
        end else begin
            raw = {$urandom, $urandom} & RAW_ALL_ONES;
        end
        if ($urandom_range(0, 1) == 0) begin
            send_word(csc_pkg::ACT_TO_CAL, raw, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
        end else if (mode < 7) begin
            send_word(csc_pkg::ACT_TO_SEC, raw, $urandom_range(0, csc_pkg::MAX_YEAR),
                      $urandom_range(1, 12), $urandom_range(1, 31),
                      $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59));
        end else begin
            send_word(csc_pkg::ACT_TO_SEC, raw, $urandom_range(0, 16383),
                      $urandom_range(0, 15), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 63),
                      $urandom_range(0, 63));
        end
    endtask

    task automatic drain_words();
        start <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
    endtask

    initial begin
        idle_pct      = 26;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_action      <= csc_pkg::ACT_TO_CAL;
        i_raw_seconds <= '0;
        i_in_year     <= '0;
        i_in_month    <= '0;
        i_in_day      <= '0;
        i_in_hour     <= '0;
        i_in_minute   <= '0;
        i_in_sec      <= '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // seconds to calendar: epoch, day boundary, last valid second, beyond 9999
        send_word(csc_pkg::ACT_TO_CAL, 0, 0, 0, 0, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_CAL, csc_pkg::SECS_PER_DAY - 1, 0, 0, 0, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_CAL, csc_pkg::SECS_PER_DAY, 0, 0, 0, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_CAL, RAW_MAX_OK, 0, 0, 0, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_CAL, RAW_MAX_OK + 1, 0, 0, 0, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_CAL, RAW_ALL_ONES, 16383, 15, 31, 31, 63, 63);
        // calendar to seconds: range ends and leap rules
        send_word(csc_pkg::ACT_TO_SEC, RAW_ALL_ONES, 0, 1, 1, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 9999, 12, 31, 23, 59, 59);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2000, 2, 29, 12, 30, 30);
        send_word(csc_pkg::ACT_TO_SEC, 0, 1900, 2, 29, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2004, 2, 29, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2001, 2, 29, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2001, 2, 28, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 0, 2, 29, 0, 0, 0);
        // invalid fields
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 0, 1, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 13, 1, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 15, 31, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 1, 0, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 4, 31, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 6, 15, 24, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 6, 15, 31, 63, 63);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 6, 15, 0, 60, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 2020, 6, 15, 0, 0, 60);
        send_word(csc_pkg::ACT_TO_SEC, 0, 10000, 6, 15, 0, 0, 0);
        send_word(csc_pkg::ACT_TO_SEC, 0, 16383, 12, 31, 23, 59, 59);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 26 : (phase == 1) ? 76 : 0;
            for (int k = 0; k < RANDOM_WORDS / 3; k++) send_random_word();
            drain_words();
        end

        repeat (4 * csc_pkg::LATENCY) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("calendar_seconds_converter verification clean");
        end else begin
            $display("calendar_seconds_converter verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/csc_pkg.sv
design/csc_day_div.sv
design/csc_date_split.sv
design/csc_tod_split.sv
design/csc_cal_to_secs.sv
design/calendar_seconds_converter.sv
design/csc_checker.sv
bench/csc_checker.sv
bench/calendar_seconds_converter_test.sv
